@@ sv/coordinate_graph_builder_assert.svh @@
// assertion macros shared by the graph builder modules
// CGB_ASSERT is checked outside reset only, CGB_ASSERT_ALL at every edge
`ifndef COORDINATE_GRAPH_BUILDER_ASSERT_SVH
`define COORDINATE_GRAPH_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define CGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cgb assertion failed");
`define CGB_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cgb assertion failed");
`else
`define CGB_ASSERT(lbl, prop)
`define CGB_ASSERT_ALL(lbl, prop)
`endif
`endif

@@ sv/cgb_pkg.sv @@
`timescale 1ns / 1ps
package cgb_pkg;

  localparam int unsigned MAX_VERTICES = 512;
  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned VCNT_W = $clog2(MAX_VERTICES + 1);

  localparam int unsigned LON_W = 32;
  localparam int unsigned LAT_W = 31;
  localparam int unsigned VERTEX_W = LON_W + LAT_W;

  localparam int unsigned TOL_W = 10;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam int unsigned EDGE_W = 17;
  localparam logic [EDGE_W-1:0] EDGE_LIMIT = {EDGE_W{1'b1}};

  // adjacency matrix packed in 64-bit words, row-major bit order
  localparam int unsigned ADJ_WORD_W = 64;
  localparam int unsigned ADJ_SEL_W = 6;
  localparam int unsigned ADJ_WORDS = (MAX_VERTICES * MAX_VERTICES + ADJ_WORD_W - 1) / ADJ_WORD_W;
  localparam int unsigned ADJ_AW = (ADJ_WORDS > 1) ? $clog2(ADJ_WORDS) : 1;
  localparam int unsigned ADJ_BIT_W = ADJ_AW + ADJ_SEL_W;

  typedef logic [VIDX_W-1:0] vidx_t;

  typedef struct packed {
    logic  valid;
    vidx_t from_v;
    vidx_t to_v;
  } adj_req_t;

  typedef struct packed {
    logic clearing;
    logic done;
    logic added;
  } adj_rsp_t;

endpackage

@@ sv/cgb_ram.sv @@
`timescale 1ns / 1ps
module cgb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cgb_adj.sv @@
`timescale 1ns / 1ps
`include "coordinate_graph_builder_assert.svh"
module cgb_adj (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgb_pkg::adj_req_t req_i,
  output cgb_pkg::adj_rsp_t rsp_o
);
  import cgb_pkg::*;

  typedef enum logic [2:0] {
    A_CLEAR,
    A_IDLE,
    A_RD_B,
    A_CHK,
    A_WR_B
  } adj_state_e;

  adj_state_e state_q;
  logic [ADJ_AW-1:0] clr_q;
  logic done_q, added_q;

  logic [ADJ_AW-1:0]    addr_a_q, addr_b_q;
  logic [ADJ_SEL_W-1:0] sel_a_q, sel_b_q;
  logic [ADJ_WORD_W-1:0] word_a_q, word_b_q;

  logic [ADJ_BIT_W-1:0] bit_ab, bit_ba;
  logic [ADJ_AW-1:0]    addr_a, addr_b;

  logic                  ram_we;
  logic [ADJ_AW-1:0]     ram_waddr, ram_raddr;
  logic [ADJ_WORD_W-1:0] ram_wdata, ram_rdata;

  // bit index = row * MAX_VERTICES + column
  assign bit_ab = ADJ_BIT_W'(req_i.from_v) * ADJ_BIT_W'(MAX_VERTICES) + ADJ_BIT_W'(req_i.to_v);
  assign bit_ba = ADJ_BIT_W'(req_i.to_v) * ADJ_BIT_W'(MAX_VERTICES) + ADJ_BIT_W'(req_i.from_v);
  assign addr_a = bit_ab[ADJ_BIT_W-1:ADJ_SEL_W];
  assign addr_b = bit_ba[ADJ_BIT_W-1:ADJ_SEL_W];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = addr_a;
    unique case (state_q)
      A_CLEAR: begin
        ram_we = 1'b1;
      end
      A_IDLE: begin
        ram_raddr = addr_a;
      end
      A_RD_B: begin
        ram_raddr = addr_b_q;
      end
      A_CHK: begin
        // word a arrived last cycle; set its bit unless the edge exists
        ram_we    = !word_a_q[sel_a_q];
        ram_waddr = addr_a_q;
        ram_wdata = word_a_q | (ADJ_WORD_W'(1) << sel_a_q);
      end
      A_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_q;
        ram_wdata = word_b_q | (ADJ_WORD_W'(1) << sel_b_q);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      added_q <= 1'b0;
    end else begin
      done_q  <= (state_q == A_WR_B) || (state_q == A_CHK && word_a_q[sel_a_q]);
      added_q <= (state_q == A_WR_B);
      unique case (state_q)
        A_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADJ_AW'(ADJ_WORDS - 1)) begin
            state_q <= A_IDLE;
          end
        end
        A_IDLE: begin
          if (req_i.valid) begin
            state_q <= A_RD_B;
          end
        end
        A_RD_B: begin
          state_q <= A_CHK;
        end
        A_CHK: begin
          if (word_a_q[sel_a_q]) begin
            state_q <= A_IDLE;
          end else begin
            state_q <= A_WR_B;
          end
        end
        A_WR_B: begin
          state_q <= A_IDLE;
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == A_IDLE && req_i.valid) begin
      addr_a_q <= addr_a;
      addr_b_q <= addr_b;
      sel_a_q  <= bit_ab[ADJ_SEL_W-1:0];
      sel_b_q  <= bit_ba[ADJ_SEL_W-1:0];
    end
    if (state_q == A_RD_B) begin
      word_a_q <= ram_rdata;
    end
    if (state_q == A_CHK) begin
      word_b_q <= ram_rdata;
    end
  end

  cgb_ram #(
    .WIDTH(ADJ_WORD_W),
    .DEPTH(ADJ_WORDS)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rsp_o.clearing = (state_q == A_CLEAR);
  assign rsp_o.done     = done_q;
  assign rsp_o.added    = added_q;

  `CGB_ASSERT(a_req_when_idle, req_i.valid |-> state_q == A_IDLE)
  `CGB_ASSERT(a_words_distinct, (state_q == A_IDLE && req_i.valid) |-> addr_a != addr_b)
  `CGB_ASSERT(a_clear_complete, $fell(rsp_o.clearing) |-> $past(clr_q) == ADJ_AW'(ADJ_WORDS - 1))
  `CGB_ASSERT(a_added_implies_done, added_q |-> done_q)

endmodule

@@ sv/coordinate_graph_builder.sv @@
`timescale 1ns / 1ps
// coordinate graph builder: deduplicates polyline points into vertices and
// records undirected edges between consecutive distinct vertices of a way.
// input channel: lon_i, lat_i, first_of_way_i with in_valid_i / in_ready_o.
// output channel: one result per point with out_valid_o / out_ready_i.
// match_tolerance is written through cfg_wdata_i / cfg_we_i while idle;
// the user must keep to this, as the block itself does not enforce it.
// one point is processed at a time. the vertex table is scanned one entry
// per cycle through a single-port read of the vertex ram. an existing edge
// is found by checking one word of the adjacency ram, and a new one is
// written by a read-modify-write of both symmetric words.
// a match ends the scan early. the next point is taken in the cycle after
// the result is registered.
// after reset the adjacency ram is cleared one 64-bit word per cycle, all
// 4096 words, and in_ready_o stays low until that pass is done.
// the result sits in an output register; the next point is taken while it
// waits, and the block stalls only before writing a new result into a full
// output register.
`include "coordinate_graph_builder_assert.svh"
module coordinate_graph_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cgb_pkg::TOL_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cgb_pkg::LON_W-1:0]    lon_i,
  input  logic [cgb_pkg::LAT_W-1:0]    lat_i,
  input  logic                         first_of_way_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cgb_pkg::VIDX_W-1:0]   vertex_index_o,
  output logic                         created_o,
  output logic                         edge_added_o,
  output logic                         table_full_o,
  output logic [cgb_pkg::VCNT_W-1:0]   vertices_stored_o,
  output logic [cgb_pkg::EDGE_W-1:0]   edges_stored_o
);
  import cgb_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_EDGE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic [TOL_W-1:0]  tol_q;
  logic [LON_W-1:0]  lon_q;
  logic [LAT_W-1:0]  lat_q;
  logic              first_q;
  logic [VCNT_W-1:0] vcount_q;
  logic [EDGE_W-1:0] edges_q;
  vidx_t             prev_q;
  logic              prev_valid_q;

  logic [VCNT_W-1:0] issue_q;
  logic              cmp_valid_q;
  vidx_t             cmp_idx_q;
  logic              hit_q;
  vidx_t             hit_idx_q;

  vidx_t res_idx_q;
  logic  res_created_q, res_full_q, res_edge_q;

  logic              out_valid_q;
  vidx_t             out_idx_q;
  logic              out_created_q, out_edge_q, out_full_q;
  logic [VCNT_W-1:0] out_vcount_q;
  logic [EDGE_W-1:0] out_edges_q;

  logic                issue_go;
  logic [VERTEX_W-1:0] vram_rdata;
  logic [LON_W-1:0]    rd_lon;
  logic [LAT_W-1:0]    rd_lat;
  logic signed [LON_W:0] d_lon, tol_lon;
  logic signed [LAT_W:0] d_lat, tol_lat;
  logic                lon_ok, lat_ok, match;

  logic  can_append, is_full, want_edge, vram_we, out_free;
  vidx_t new_idx;

  adj_req_t adj_req;
  adj_rsp_t adj_rsp;

  // scan: address issued in one cycle, compared the next
  assign issue_go = (state_q == ST_SEARCH) && (issue_q < vcount_q);

  assign rd_lon  = vram_rdata[LON_W-1:0];
  assign rd_lat  = vram_rdata[VERTEX_W-1:LON_W];
  assign d_lon   = $signed({rd_lon[LON_W-1], rd_lon}) - $signed({lon_q[LON_W-1], lon_q});
  assign d_lat   = $signed({rd_lat[LAT_W-1], rd_lat}) - $signed({lat_q[LAT_W-1], lat_q});
  assign tol_lon = $signed({{(LON_W + 1 - TOL_W){1'b0}}, tol_q});
  assign tol_lat = $signed({{(LAT_W + 1 - TOL_W){1'b0}}, tol_q});
  assign lon_ok  = (d_lon < tol_lon) && (d_lon > -tol_lon);
  assign lat_ok  = (d_lat < tol_lat) && (d_lat > -tol_lat);
  assign match   = cmp_valid_q && lon_ok && lat_ok;

  assign can_append = !hit_q && (vcount_q < VCNT_W'(MAX_VERTICES));
  assign is_full    = !hit_q && !can_append;
  assign new_idx    = hit_q ? hit_idx_q : (can_append ? vcount_q[VIDX_W-1:0] : '0);
  assign want_edge  = !is_full && !first_q && prev_valid_q && (prev_q != new_idx);
  assign vram_we    = (state_q == ST_DECIDE) && can_append;
  assign out_free   = !out_valid_q || out_ready_i;

  assign adj_req.valid  = (state_q == ST_DECIDE) && want_edge;
  assign adj_req.from_v = prev_q;
  assign adj_req.to_v   = new_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      tol_q         <= TOL_RESET;
      vcount_q      <= '0;
      edges_q       <= '0;
      prev_q        <= '0;
      prev_valid_q  <= 1'b0;
      issue_q       <= '0;
      cmp_valid_q   <= 1'b0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          if (!adj_rsp.clearing) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            issue_q     <= '0;
            cmp_valid_q <= 1'b0;
            state_q     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          cmp_valid_q <= issue_go;
          if (issue_go) begin
            issue_q <= issue_q + 1'b1;
          end
          if (match) begin
            hit_q   <= 1'b1;
            state_q <= ST_DECIDE;
          end else if (!cmp_valid_q && !issue_go) begin
            hit_q   <= 1'b0;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (can_append) begin
            vcount_q <= vcount_q + 1'b1;
          end
          // a full table breaks the way
          if (is_full) begin
            prev_valid_q <= 1'b0;
          end else begin
            prev_q       <= new_idx;
            prev_valid_q <= 1'b1;
          end
          state_q <= want_edge ? ST_EDGE : ST_EMIT;
        end
        ST_EDGE: begin
          if (adj_rsp.done) begin
            if (adj_rsp.added && edges_q != EDGE_LIMIT) begin
              edges_q <= edges_q + 1'b1;
            end
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      lon_q   <= lon_i;
      lat_q   <= lat_i;
      first_q <= first_of_way_i;
    end
    cmp_idx_q <= issue_q[VIDX_W-1:0];
    if (state_q == ST_SEARCH && match) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (state_q == ST_DECIDE) begin
      res_idx_q     <= new_idx;
      res_created_q <= can_append;
      res_full_q    <= is_full;
      res_edge_q    <= 1'b0;
    end
    if (state_q == ST_EDGE && adj_rsp.done) begin
      res_edge_q <= adj_rsp.added;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_idx_q     <= res_idx_q;
      out_created_q <= res_created_q;
      out_edge_q    <= res_edge_q;
      out_full_q    <= res_full_q;
      out_vcount_q  <= vcount_q;
      out_edges_q   <= edges_q;
    end
  end

  cgb_ram #(
    .WIDTH(VERTEX_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(vcount_q[VIDX_W-1:0]),
    .wdata_i({lat_q, lon_q}),
    .raddr_i(issue_q[VIDX_W-1:0]),
    .rdata_o(vram_rdata)
  );

  cgb_adj u_adj (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (adj_req),
    .rsp_o (adj_rsp)
  );

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign vertex_index_o    = out_idx_q;
  assign created_o         = out_created_q;
  assign edge_added_o      = out_edge_q;
  assign table_full_o      = out_full_q;
  assign vertices_stored_o = out_vcount_q;
  assign edges_stored_o    = out_edges_q;

  `CGB_ASSERT_ALL(a_vcount_bound, vcount_q <= VCNT_W'(MAX_VERTICES))
  `CGB_ASSERT(a_full_result, (out_valid_o && table_full_o) |-> (!created_o && !edge_added_o && vertex_index_o == '0))
  `CGB_ASSERT(a_append_counts, vram_we |=> vcount_q == $past(vcount_q) + 1'b1)
  `CGB_ASSERT(a_no_self_edge, adj_req.valid |-> adj_req.from_v != adj_req.to_v)

endmodule
